@@ sv/scbp_pkg.sv @@
`timescale 1ns / 1ps
package scbp_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int MAX_SLOTS   = 256;
  localparam int CLS_W       = 2;
  localparam int SLOT_W      = 8;
  localparam int PTR_W       = 9;
  localparam int SIZE_W      = 17;
  localparam int COUNT_W     = 9;
  localparam int REQ_W       = 24;
  localparam int OFFSET_W    = 24;
  localparam int LINK_DEPTH  = NUM_CLASSES * MAX_SLOTS;
  localparam int LINK_AW     = CLS_W + SLOT_W;

  localparam logic [PTR_W-1:0]   PTR_EMPTY = PTR_W'(MAX_SLOTS);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_SLOTS);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_INIT    = 2'd2;

  localparam logic [CLS_W-1:0] CLASS_UNPOOLED = 2'd3;

  localparam logic [2:0] ST_GRANTED     = 3'd0;
  localparam logic [2:0] ST_OVERSIZE    = 3'd1;
  localparam logic [2:0] ST_FALLBACK    = 3'd2;
  localparam logic [2:0] ST_RETRY       = 3'd3;
  localparam logic [2:0] ST_RELEASED    = 3'd4;
  localparam logic [2:0] ST_REL_IGNORED = 3'd5;
  localparam logic [2:0] ST_INITIALIZED = 3'd6;

  localparam logic [2:0] REG_CLASS0_SIZE  = 3'd0;
  localparam logic [2:0] REG_CLASS1_SIZE  = 3'd1;
  localparam logic [2:0] REG_CLASS2_SIZE  = 3'd2;
  localparam logic [2:0] REG_CLASS0_COUNT = 3'd3;
  localparam logic [2:0] REG_CLASS1_COUNT = 3'd4;
  localparam logic [2:0] REG_CLASS2_COUNT = 3'd5;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd256;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd16;

  typedef logic [NUM_CLASSES-1:0][SIZE_W-1:0]  size_arr_t;
  typedef logic [NUM_CLASSES-1:0][COUNT_W-1:0] count_arr_t;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic pop_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_pop;
  } dp_status_t;

endpackage

@@ sv/scbp_ram.sv @@
`timescale 1ns / 1ps
module scbp_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/scbp_ctrl.sv @@
`timescale 1ns / 1ps
module scbp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  scbp_pkg::dp_status_t   st,
  output scbp_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        // Execution waits until the output register can take the result.
        if (st.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = st.need_pop ? S_POP : S_IDLE;
        end
      end
      S_POP: begin
        cmd.pop_done = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/scbp_dp.sv @@
`timescale 1ns / 1ps
module scbp_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  scbp_pkg::ctrl_cmd_t                    cmd,
  output scbp_pkg::dp_status_t                   st,
  input  scbp_pkg::size_arr_t                    cls_size,
  input  scbp_pkg::count_arr_t                   cls_count,
  input  logic [1:0]                             in_op,
  input  logic [scbp_pkg::REQ_W-1:0]             in_req_size,
  input  logic                                   in_wait_flag,
  input  logic [scbp_pkg::CLS_W-1:0]             in_release_class,
  input  logic [scbp_pkg::SLOT_W-1:0]            in_release_slot,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [2:0]                             out_status,
  output logic [scbp_pkg::CLS_W-1:0]             out_grant_class,
  output logic [scbp_pkg::SLOT_W-1:0]            out_grant_slot,
  output logic [scbp_pkg::OFFSET_W-1:0]          out_grant_offset
);

  localparam int NC   = scbp_pkg::NUM_CLASSES;
  localparam int PW   = scbp_pkg::PTR_W;
  localparam int SW   = scbp_pkg::SLOT_W;
  localparam int ZW   = scbp_pkg::SIZE_W;
  localparam int CW   = scbp_pkg::CLS_W;
  localparam int KW   = scbp_pkg::COUNT_W;
  localparam int RW   = scbp_pkg::REQ_W;
  localparam int OW   = scbp_pkg::OFFSET_W;
  localparam int PRDW = SW + ZW;

  // Captured item.
  logic [1:0]    op_r;
  logic [RW-1:0] req_r;
  logic          wait_r;
  logic [CW-1:0] rcls_r;
  logic [SW-1:0] rslot_r;

  // Free-list state: stack heads and bump counters per class.
  logic [NC-1:0][PW-1:0] head_r, head_nxt;
  logic [NC-1:0][KW-1:0] fresh_r, fresh_nxt;

  logic [CW-1:0] sel_cls_r;
  logic [SW-1:0] sel_slot_r;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    status_r;
  logic [CW-1:0] gcls_r;
  logic [SW-1:0] gslot_r;
  logic [OW-1:0] goff_r;

  logic          oversize;
  logic          found;
  logic [CW-1:0] fcls;
  logic          from_stack;
  logic [SW-1:0] cand_slot;
  logic          need_pop;
  logic [CW-1:0] rcls_idx;
  logic          rel_ok;
  logic [SW-1:0] mul_slot;
  logic [ZW-1:0] mul_size;
  logic [PRDW-1:0] prod;
  logic          load_out;
  logic [2:0]    res_status;
  logic [CW-1:0] res_cls;
  logic [SW-1:0] res_slot;
  logic [OW-1:0] res_off;
  logic [KW-1:0] eff_count;
  logic          fits;
  logic          avail;

  logic                          ram_we;
  logic [scbp_pkg::LINK_AW-1:0]  ram_waddr;
  logic [scbp_pkg::LINK_AW-1:0]  ram_raddr;
  logic [PW-1:0]                 ram_rdata;

  // Class search: first class that fits the request and has a free slot.
  always_comb begin
    found     = 1'b0;
    fcls      = '0;
    eff_count = '0;
    fits      = 1'b0;
    avail     = 1'b0;
    oversize  = req_r > RW'(cls_size[NC-1]);
    for (int c = 0; c < NC; c++) begin
      eff_count = (cls_count[c] > scbp_pkg::COUNT_MAX) ? scbp_pkg::COUNT_MAX : cls_count[c];
      fits      = RW'(cls_size[c]) >= req_r;
      avail     = !head_r[c][PW-1] || (fresh_r[c] < eff_count);
      if (!found && fits && avail) begin
        found = 1'b1;
        fcls  = CW'(c);
      end
    end
  end

  assign from_stack = !head_r[fcls][PW-1];
  assign cand_slot  = from_stack ? head_r[fcls][SW-1:0] : fresh_r[fcls][SW-1:0];
  assign need_pop   = (op_r == scbp_pkg::OP_ALLOC) && !oversize && found && from_stack;

  assign rcls_idx = (rcls_r == scbp_pkg::CLASS_UNPOOLED) ? '0 : rcls_r;
  assign rel_ok   = (rcls_r != scbp_pkg::CLASS_UNPOOLED) &&
                    ({1'b0, rslot_r} < fresh_r[rcls_idx]);

  // One shared offset multiplier, fed either by the fresh grant or the popped slot.
  assign mul_slot = cmd.pop_done ? sel_slot_r : cand_slot;
  assign mul_size = cmd.pop_done ? cls_size[sel_cls_r] : cls_size[fcls];
  assign prod     = PRDW'(mul_slot) * PRDW'(mul_size);

  always_comb begin
    res_status = scbp_pkg::ST_GRANTED;
    res_cls    = '0;
    res_slot   = '0;
    res_off    = '0;
    if (cmd.pop_done) begin
      res_cls  = sel_cls_r;
      res_slot = sel_slot_r;
      res_off  = prod[OW-1:0];
    end else begin
      case (op_r)
        scbp_pkg::OP_ALLOC: begin
          if (oversize) begin
            res_status = scbp_pkg::ST_OVERSIZE;
          end else if (found) begin
            res_cls  = fcls;
            res_slot = cand_slot;
            res_off  = prod[OW-1:0];
          end else begin
            res_status = wait_r ? scbp_pkg::ST_RETRY : scbp_pkg::ST_FALLBACK;
          end
        end
        scbp_pkg::OP_RELEASE: begin
          res_status = rel_ok ? scbp_pkg::ST_RELEASED : scbp_pkg::ST_REL_IGNORED;
        end
        scbp_pkg::OP_INIT: begin
          res_status = scbp_pkg::ST_INITIALIZED;
        end
        default: begin
          res_status = scbp_pkg::ST_GRANTED;
        end
      endcase
    end
  end

  // An unused op code produces no result item.
  assign load_out = (cmd.exec && !need_pop &&
                     (op_r == scbp_pkg::OP_ALLOC || op_r == scbp_pkg::OP_RELEASE ||
                      op_r == scbp_pkg::OP_INIT)) || cmd.pop_done;

  always_comb begin
    head_nxt  = head_r;
    fresh_nxt = fresh_r;
    if (cmd.exec) begin
      case (op_r)
        scbp_pkg::OP_ALLOC: begin
          if (!oversize && found && !from_stack) begin
            fresh_nxt[fcls] = fresh_r[fcls] + KW'(1);
          end
        end
        scbp_pkg::OP_RELEASE: begin
          if (rel_ok) begin
            head_nxt[rcls_idx] = PW'(rslot_r);
          end
        end
        scbp_pkg::OP_INIT: begin
          for (int c = 0; c < NC; c++) begin
            head_nxt[c]  = scbp_pkg::PTR_EMPTY;
            fresh_nxt[c] = '0;
          end
        end
        default: begin
          head_nxt = head_r;
        end
      endcase
    end
    if (cmd.pop_done) begin
      head_nxt[sel_cls_r] = ram_rdata;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NC; c++) begin
        head_r[c]  <= scbp_pkg::PTR_EMPTY;
        fresh_r[c] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r    <= in_op;
      req_r   <= in_req_size;
      wait_r  <= in_wait_flag;
      rcls_r  <= in_release_class;
      rslot_r <= in_release_slot;
    end
    if (cmd.exec && need_pop) begin
      sel_cls_r  <= fcls;
      sel_slot_r <= cand_slot;
    end
    if (load_out) begin
      status_r <= res_status;
      gcls_r   <= res_cls;
      gslot_r  <= res_slot;
      goff_r   <= res_off;
    end
  end

  // A release writes the old head as the link of the pushed slot.
  assign ram_we    = cmd.exec && (op_r == scbp_pkg::OP_RELEASE) && rel_ok;
  assign ram_waddr = {rcls_idx, rslot_r};
  assign ram_raddr = {fcls, head_r[fcls][SW-1:0]};

  scbp_ram #(
    .WIDTH (scbp_pkg::PTR_W),
    .DEPTH (scbp_pkg::LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (head_r[rcls_idx]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign st.out_free = !out_valid_r || out_ready;
  assign st.need_pop = need_pop;

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_grant_class  = gcls_r;
  assign out_grant_slot   = gslot_r;
  assign out_grant_offset = goff_r;

endmodule

@@ sv/size_class_buffer_pool.sv @@
`timescale 1ns / 1ps
// Buffer pool allocator with three size classes, each a LIFO free list of slots held as a
// stack head plus a bump counter, with the per-slot links in a 768-entry link RAM. An item
// is captured in idle and executed once the output register can take the result; an
// allocation served from a freed slot then passes a pop state, as the link of the popped
// slot comes out of the registered read port of the link RAM. The next item is taken as
// soon as the controller is back in idle, even while the last result still waits in the
// output register; execution only holds when that register is still full. The link RAM
// needs no clearing after reset; pools are usable at once. The user must write class
// sizes and counts via the APB port only while the pool is idle, unenforced by the block.
module size_class_buffer_pool (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_op,
  input  logic [scbp_pkg::REQ_W-1:0]             in_req_size,
  input  logic                                   in_wait_flag,
  input  logic [scbp_pkg::CLS_W-1:0]             in_release_class,
  input  logic [scbp_pkg::SLOT_W-1:0]            in_release_slot,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [2:0]                             out_status,
  output logic [scbp_pkg::CLS_W-1:0]             out_grant_class,
  output logic [scbp_pkg::SLOT_W-1:0]            out_grant_slot,
  output logic [scbp_pkg::OFFSET_W-1:0]          out_grant_offset,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [4:0]                             cfg_paddr,
  input  logic [31:0]                            cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);

  scbp_pkg::size_arr_t  size_r, size_nxt;
  scbp_pkg::count_arr_t count_r, count_nxt;
  logic                 wr_en;
  logic [2:0]           reg_idx;
  scbp_pkg::ctrl_cmd_t  cmd;
  scbp_pkg::dp_status_t st;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  always_comb begin
    size_nxt  = size_r;
    count_nxt = count_r;
    if (wr_en) begin
      unique case (reg_idx)
        scbp_pkg::REG_CLASS0_SIZE:  size_nxt[0]  = cfg_pwdata[scbp_pkg::SIZE_W-1:0];
        scbp_pkg::REG_CLASS1_SIZE:  size_nxt[1]  = cfg_pwdata[scbp_pkg::SIZE_W-1:0];
        scbp_pkg::REG_CLASS2_SIZE:  size_nxt[2]  = cfg_pwdata[scbp_pkg::SIZE_W-1:0];
        scbp_pkg::REG_CLASS0_COUNT: count_nxt[0] = cfg_pwdata[scbp_pkg::COUNT_W-1:0];
        scbp_pkg::REG_CLASS1_COUNT: count_nxt[1] = cfg_pwdata[scbp_pkg::COUNT_W-1:0];
        scbp_pkg::REG_CLASS2_COUNT: count_nxt[2] = cfg_pwdata[scbp_pkg::COUNT_W-1:0];
        default: begin
          size_nxt = size_r;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      scbp_pkg::REG_CLASS0_SIZE:  cfg_prdata = 32'(size_r[0]);
      scbp_pkg::REG_CLASS1_SIZE:  cfg_prdata = 32'(size_r[1]);
      scbp_pkg::REG_CLASS2_SIZE:  cfg_prdata = 32'(size_r[2]);
      scbp_pkg::REG_CLASS0_COUNT: cfg_prdata = 32'(count_r[0]);
      scbp_pkg::REG_CLASS1_COUNT: cfg_prdata = 32'(count_r[1]);
      scbp_pkg::REG_CLASS2_COUNT: cfg_prdata = 32'(count_r[2]);
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
        size_r[c]  <= scbp_pkg::SIZE_RESET;
        count_r[c] <= scbp_pkg::COUNT_RESET;
      end
    end else begin
      size_r  <= size_nxt;
      count_r <= count_nxt;
    end
  end

  scbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  scbp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cls_size         (size_r),
    .cls_count        (count_r),
    .in_op            (in_op),
    .in_req_size      (in_req_size),
    .in_wait_flag     (in_wait_flag),
    .in_release_class (in_release_class),
    .in_release_slot  (in_release_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_grant_class  (out_grant_class),
    .out_grant_slot   (out_grant_slot),
    .out_grant_offset (out_grant_offset)
  );

endmodule

@@ bench/pool_monitor.sv @@
`timescale 1ns / 1ps
module pool_monitor
  import scbp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [REQ_W-1:0]    in_req_size,
  input  logic                in_wait_flag,
  input  logic [CLS_W-1:0]    in_release_class,
  input  logic [SLOT_W-1:0]   in_release_slot,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [2:0]          out_status,
  input  logic [CLS_W-1:0]    out_grant_class,
  input  logic [SLOT_W-1:0]   out_grant_slot,
  input  logic [OFFSET_W-1:0] out_grant_offset,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic                cfg_pready,
  output int                  mismatches,
  output int                  outstanding
);

  typedef struct packed {
    logic [2:0]          status;
    logic [CLS_W-1:0]    grant_class;
    logic [SLOT_W-1:0]   grant_slot;
    logic [OFFSET_W-1:0] grant_offset;
  } pool_answer_t;

  logic [SIZE_W-1:0]  class_size  [NUM_CLASSES];
  logic [COUNT_W-1:0] class_count [NUM_CLASSES];
  logic [PTR_W-1:0]   free_head   [NUM_CLASSES];
  logic [COUNT_W-1:0] bump_count  [NUM_CLASSES];
  logic [PTR_W-1:0]   free_link   [NUM_CLASSES][MAX_SLOTS];

  pool_answer_t expected_answers[$];

  // Applies one item to the shadow pools; returns 0 for an op that gives no answer.
  function automatic bit pool_step(input logic [1:0] op, input logic [REQ_W-1:0] req,
                                   input logic wait_flag, input logic [CLS_W-1:0] rcls,
                                   input logic [SLOT_W-1:0] rslot, output pool_answer_t ans);
    logic [PTR_W-1:0]   slot;
    logic [COUNT_W-1:0] limit;
    logic [47:0]        product;
    bit                 got;
    ans = '0;
    pool_step = 1'b1;
    got = 1'b0;
    case (op)
      OP_ALLOC: begin
        if (req > class_size[NUM_CLASSES-1]) begin
          ans.status = ST_OVERSIZE;
        end else begin
          ans.status = wait_flag ? ST_RETRY : ST_FALLBACK;
          for (int c = 0; c < NUM_CLASSES; c++) begin
            if (!got && req <= class_size[c]) begin
              limit = (class_count[c] > COUNT_MAX) ? COUNT_MAX : class_count[c];
              if (free_head[c] < PTR_EMPTY) begin
                slot = free_head[c];
                free_head[c] = free_link[c][slot[SLOT_W-1:0]];
                got = 1'b1;
              end else if (bump_count[c] < limit) begin
                slot = bump_count[c];
                bump_count[c] = bump_count[c] + 1'b1;
                got = 1'b1;
              end
              if (got) begin
                product = slot * class_size[c];
                ans.status       = ST_GRANTED;
                ans.grant_class  = CLS_W'(c);
                ans.grant_slot   = slot[SLOT_W-1:0];
                ans.grant_offset = product[OFFSET_W-1:0];
              end
            end
          end
        end
      end
      OP_RELEASE: begin
        // Unpooled buffers and slots never handed out since the last init are ignored.
        if (rcls == CLASS_UNPOOLED || {1'b0, rslot} >= bump_count[rcls]) begin
          ans.status = ST_REL_IGNORED;
        end else begin
          free_link[rcls][rslot] = free_head[rcls];
          free_head[rcls] = {1'b0, rslot};
          ans.status = ST_RELEASED;
        end
      end
      OP_INIT: begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          free_head[c]  = PTR_EMPTY;
          bump_count[c] = '0;
        end
        ans.status = ST_INITIALIZED;
      end
      default: pool_step = 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    pool_answer_t ans;
    pool_answer_t want;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        class_size[c]  = SIZE_RESET;
        class_count[c] = COUNT_RESET;
        free_head[c]   = PTR_EMPTY;
        bump_count[c]  = '0;
        for (int s = 0; s < MAX_SLOTS; s++) free_link[c][s] = '0;
      end
      expected_answers.delete();
      mismatches = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_CLASS0_SIZE:  class_size[0]  = cfg_pwdata[SIZE_W-1:0];
          REG_CLASS1_SIZE:  class_size[1]  = cfg_pwdata[SIZE_W-1:0];
          REG_CLASS2_SIZE:  class_size[2]  = cfg_pwdata[SIZE_W-1:0];
          REG_CLASS0_COUNT: class_count[0] = cfg_pwdata[COUNT_W-1:0];
          REG_CLASS1_COUNT: class_count[1] = cfg_pwdata[COUNT_W-1:0];
          REG_CLASS2_COUNT: class_count[2] = cfg_pwdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result item: status %0d", out_status);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            mismatches++;
          end
          if (out_grant_class !== want.grant_class) begin
            $error("grant_class: expected %0d, actual %0d", want.grant_class, out_grant_class);
            mismatches++;
          end
          if (out_grant_slot !== want.grant_slot) begin
            $error("grant_slot: expected %0d, actual %0d", want.grant_slot, out_grant_slot);
            mismatches++;
          end
          if (out_grant_offset !== want.grant_offset) begin
            $error("grant_offset: expected %0d, actual %0d", want.grant_offset,
                   out_grant_offset);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (pool_step(in_op, in_req_size, in_wait_flag, in_release_class, in_release_slot,
                      ans)) begin
          expected_answers.push_back(ans);
        end
      end
    end
    outstanding = expected_answers.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import scbp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_op;
  logic [REQ_W-1:0]    in_req_size;
  logic                in_wait_flag;
  logic [CLS_W-1:0]    in_release_class;
  logic [SLOT_W-1:0]   in_release_slot;
  logic                out_valid;
  logic                out_ready;
  logic [2:0]          out_status;
  logic [CLS_W-1:0]    out_grant_class;
  logic [SLOT_W-1:0]   out_grant_slot;
  logic [OFFSET_W-1:0] out_grant_offset;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [4:0]          cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  int mismatches;
  int outstanding;
  int cfg_size_now  [NUM_CLASSES];
  int cfg_count_now [NUM_CLASSES];
  bit quiet;
  bit hold_req;

  size_class_buffer_pool dut (.*);

  pool_monitor monitor (.*);

  always #2 clk = ~clk;

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : ready_driver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_left = 299;
        hold_done = 1'b1;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic offer(input logic [1:0] op, input logic [REQ_W-1:0] req, input logic wt,
                       input logic [CLS_W-1:0] rc, input logic [SLOT_W-1:0] rs);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_req_size      <= req;
    in_wait_flag     <= wt;
    in_release_class <= rc;
    in_release_slot  <= rs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Waits until every answer is back, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
  endtask

  task automatic set_pools(input int s0, input int s1, input int s2,
                           input int c0, input int c1, input int c2);
    drain();
    write_reg(REG_CLASS0_SIZE, s0);
    write_reg(REG_CLASS1_SIZE, s1);
    write_reg(REG_CLASS2_SIZE, s2);
    write_reg(REG_CLASS0_COUNT, c0);
    write_reg(REG_CLASS1_COUNT, c1);
    write_reg(REG_CLASS2_COUNT, c2);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_size_now  = '{s0, s1, s2};
    cfg_count_now = '{c0, c1, c2};
  endtask

  task automatic random_phase(input int n, input int alloc_pct, input bit with_init,
                              input bit mid_pause);
    int                done;
    int                r;
    int                c;
    int                lim;
    bit                paused;
    logic [1:0]        op;
    logic [REQ_W-1:0]  req;
    logic              wt;
    logic [CLS_W-1:0]  rc;
    logic [SLOT_W-1:0] rs;
    done   = 0;
    paused = 1'b0;
    while (done < n) begin
      if (mid_pause && !paused && done >= n / 2) begin
        drain();
        paused = 1'b1;
      end
      r   = $urandom_range(0, 99);
      c   = $urandom_range(0, NUM_CLASSES - 1);
      req = REQ_W'($urandom);
      wt  = 1'($urandom);
      rc  = CLS_W'($urandom);
      rs  = SLOT_W'($urandom);
      if (r < alloc_pct) begin
        op = OP_ALLOC;
        case ($urandom_range(0, 9))
          0: ;
          1: req = REQ_W'(cfg_size_now[c]);
          2: req = REQ_W'(cfg_size_now[c] + 1);
          default: req = REQ_W'($urandom_range(0, cfg_size_now[c]));
        endcase
      end else if (r < alloc_pct + 2) begin
        op = OP_UNUSED;
      end else if (with_init && r < alloc_pct + 4) begin
        op = OP_INIT;
      end else begin
        op = OP_RELEASE;
        rc = ($urandom_range(0, 9) == 0) ? CLASS_UNPOOLED : CLS_W'(c);
        // Mostly slots that may have been handed out, now and then any slot.
        lim = (cfg_count_now[c] > 255) ? 255 : cfg_count_now[c];
        if ($urandom_range(0, 9) != 0) rs = SLOT_W'($urandom_range(0, lim));
      end
      offer(op, req, wt, rc, rs);
      if (op != OP_UNUSED) done++;
    end
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = OP_ALLOC;
    in_req_size      = '0;
    in_wait_flag     = 1'b0;
    in_release_class = '0;
    in_release_slot  = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    quiet            = 1'b0;
    hold_req         = 1'b0;
    cfg_size_now     = '{256, 256, 256};
    cfg_count_now    = '{16, 16, 16};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Pools are usable straight out of reset with the default sizes.
    offer(OP_ALLOC, 256, 1'b0, 2'd0, 8'd0);
    offer(OP_ALLOC, 257, 1'b0, 2'd0, 8'd0);

    set_pools(64, 256, 4096, 2, 3, 4);
    offer(OP_INIT, 0, 1'b0, 2'd0, 8'd0);
    offer(OP_ALLOC, 0, 1'b0, 2'd0, 8'd0);
    offer(OP_ALLOC, 64, 1'b0, 2'd0, 8'd0);
    offer(OP_ALLOC, 64, 1'b1, 2'd0, 8'd0);
    offer(OP_ALLOC, 4097, 1'b0, 2'd0, 8'd0);
    offer(OP_ALLOC, 24'hFFFFFF, 1'b1, 2'd3, 8'hFF);
    offer(OP_RELEASE, 0, 1'b0, 2'd0, 8'd1);
    // The same slot released twice ends up on the free list twice.
    offer(OP_RELEASE, 0, 1'b0, 2'd0, 8'd1);
    offer(OP_ALLOC, 1, 1'b0, 2'd0, 8'd0);
    offer(OP_ALLOC, 1, 1'b0, 2'd0, 8'd0);
    offer(OP_RELEASE, 0, 1'b0, CLASS_UNPOOLED, 8'd0);
    offer(OP_RELEASE, 0, 1'b0, 2'd1, 8'd200);
    offer(OP_RELEASE, 0, 1'b0, 2'd2, 8'd0);
    repeat (4) offer(OP_ALLOC, 4096, 1'b0, 2'd0, 8'd0);
    offer(OP_ALLOC, 4096, 1'b0, 2'd0, 8'd0);
    offer(OP_ALLOC, 4096, 1'b1, 2'd0, 8'd0);
    offer(OP_UNUSED, 24'hFFFFFF, 1'b1, 2'd3, 8'hFF);
    offer(OP_INIT, 0, 1'b0, 2'd0, 8'd0);
    offer(OP_ALLOC, 300, 1'b0, 2'd0, 8'd0);
    offer(OP_RELEASE, 0, 1'b0, 2'd2, 8'd0);
    offer(OP_ALLOC, 300, 1'b0, 2'd0, 8'd0);

    // The long hold-off on the result side falls at the start of this phase.
    set_pools(64, 256, 4096, 4, 8, 16);
    hold_req = 1'b1;
    random_phase(110, 55, 1'b1, 1'b0);

    // Counts drop below the slots already handed out.
    set_pools(1, 2, 65536, 1, 1, 1);
    random_phase(80, 50, 1'b0, 1'b0);

    // Widest sizes make the offset overflow 24 bits; a count above the slot limit.
    set_pools(131071, 131071, 131071, 256, 300, 0);
    random_phase(170, 92, 1'b0, 1'b0);

    quiet = 1'b1;
    set_pools(0, 65536, 65536, 3, 256, 256);
    random_phase(80, 50, 1'b1, 1'b1);
    quiet = 1'b0;

    set_pools(1, 1000, 70000, 511, 2, 5);
    random_phase(80, 45, 1'b1, 1'b0);

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ size_class_buffer_pool.f @@
sv/scbp_pkg.sv
sv/scbp_ram.sv
sv/scbp_ctrl.sv
sv/scbp_dp.sv
sv/size_class_buffer_pool.sv
bench/pool_monitor.sv
bench/testbench.sv
